// ===== hw/rtl/ott_pkg.sv =====
// Shared types and constants of the one-shot timer table.
package ott_pkg;

  typedef enum logic [1:0] {
    FUNC_CREATE  = 2'd0,
    FUNC_DESTROY = 2'd1,
    FUNC_FIND    = 2'd2,
    FUNC_TICK    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_REPLY  = 2'd0,
    KIND_EXPIRY = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_ID    = 2'd1,
    STAT_BAD_MODE  = 2'd2,
    STAT_BAD_OWNER = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_DEAD    = 2'd0,
    MODE_TICKS   = 2'd1,
    MODE_SECONDS = 2'd2
  } mode_t;

  localparam int unsigned IdW       = 8;
  localparam int unsigned DataW     = 32;
  localparam int unsigned FoundW    = 4;
  localparam int unsigned MaxExpiry = 16;
  localparam int unsigned ExpCntW   = 5;

endpackage

// ===== hw/rtl/one_shot_timer_table.sv =====
// One-shot timer table: slot store, sequencer and output register.
//
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------------------
//  in      | request   | in_valid, in_stall, in_func, in_slot_id, in_delay,
//          |           | in_unit_mode, in_owner_tag, in_owner_valid, in_now_seconds
//  out     | result    | out_valid, out_stall, out_kind, out_status, out_found_id,
//          |           | out_expired_owner, out_last
//
//  Steps: create and destroy register the request, then reply; find-free scans up
//  from slot 0 to the first dead or last slot; a tick visits slots in turn up to the
//  last one or MaxExpiry expiries, each visit a count/owner memory read and then an
//  evaluate step via the shared decrement/compare unit, write-back on the same port.
//  Reset: rst_n is synchronous and active low; it clears all slot modes to dead,
//  the sequencer and the output register. No clearing pass is needed.
//  Stalls: in_stall is high while a request is in work; a full output register
//  held by out_stall freezes the sequencer at its next result.
module one_shot_timer_table #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_func,
  input  logic [ott_pkg::IdW-1:0]         in_slot_id,
  input  logic [ott_pkg::DataW-1:0]       in_delay,
  input  logic [1:0]                      in_unit_mode,
  input  logic [ott_pkg::DataW-1:0]       in_owner_tag,
  input  logic                            in_owner_valid,
  input  logic [ott_pkg::DataW-1:0]       in_now_seconds,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_kind,
  output logic [1:0]                      out_status,
  output logic [ott_pkg::FoundW-1:0]      out_found_id,
  output logic [ott_pkg::DataW-1:0]       out_expired_owner,
  output logic                            out_last
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRE,
    S_DES,
    S_FND,
    S_TRD,
    S_TEV,
    S_TEND
  } state_t;

  // Sequencer and request registers
  state_t                        state_r, state_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic                          id_bad_r, id_bad_nxt;
  logic [ott_pkg::DataW-1:0]     delay_r, delay_nxt;
  logic [1:0]                    unit_r, unit_nxt;
  logic [ott_pkg::DataW-1:0]     owner_r, owner_nxt;
  logic                          ownv_r, ownv_nxt;
  logic [ott_pkg::DataW-1:0]     now_r, now_nxt;
  logic [ott_pkg::ExpCntW-1:0]   exp_cnt_r, exp_cnt_nxt;

  // Slot mode flops (reset to dead) and count/owner memories
  ott_pkg::mode_t                mode_r [NUM_SLOTS];
  logic [ott_pkg::DataW-1:0]     cnt_mem [NUM_SLOTS];
  logic [ott_pkg::DataW-1:0]     own_mem [NUM_SLOTS];
  logic [ott_pkg::DataW-1:0]     cnt_rd_r;
  logic [ott_pkg::DataW-1:0]     own_rd_r;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_kind_r, out_kind_nxt;
  logic [1:0]                    out_status_r, out_status_nxt;
  logic [ott_pkg::FoundW-1:0]    out_found_r, out_found_nxt;
  logic [ott_pkg::DataW-1:0]     out_owner_r, out_owner_nxt;
  logic                          out_last_r, out_last_nxt;

  // Write controls
  logic                          mode_we;
  ott_pkg::mode_t                mode_wdata;
  logic                          cnt_we;
  logic [ott_pkg::DataW-1:0]     cnt_wdata;
  logic                          own_we;

  // Shared arithmetic: saturating deadline add, decrement and compares
  logic [ott_pkg::DataW:0]       dl_sum;
  logic [ott_pkg::DataW-1:0]     dl_sat;
  ott_pkg::mode_t                cur_mode;
  logic                          fire;
  logic                          out_free;
  logic                          accept;
  logic [1:0]                    cre_status;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign cur_mode = mode_r[idx_r];

  assign dl_sum = {1'b0, now_r} + {1'b0, delay_r};
  assign dl_sat = dl_sum[ott_pkg::DataW] ? '1 : dl_sum[ott_pkg::DataW-1:0];

  always_comb begin
    fire = 1'b0;
    unique case (cur_mode)
      ott_pkg::MODE_TICKS:   fire = (cnt_rd_r <= ott_pkg::DataW'(1));
      ott_pkg::MODE_SECONDS: fire = (cnt_rd_r <= now_r);
      default:               fire = 1'b0;
    endcase
  end

  // Create checks in order: bad or busy id, bad unit, missing owner.
  always_comb begin
    priority if (id_bad_r || (cur_mode != ott_pkg::MODE_DEAD)) begin
      cre_status = ott_pkg::STAT_BAD_ID;
    end else if ((unit_r != ott_pkg::MODE_TICKS) && (unit_r != ott_pkg::MODE_SECONDS)) begin
      cre_status = ott_pkg::STAT_BAD_MODE;
    end else if (!ownv_r) begin
      cre_status = ott_pkg::STAT_BAD_OWNER;
    end else begin
      cre_status = ott_pkg::STAT_OK;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    id_bad_nxt     = id_bad_r;
    delay_nxt      = delay_r;
    unit_nxt       = unit_r;
    owner_nxt      = owner_r;
    ownv_nxt       = ownv_r;
    now_nxt        = now_r;
    exp_cnt_nxt    = exp_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_owner_nxt  = out_owner_r;
    out_last_nxt   = out_last_r;
    mode_we        = 1'b0;
    mode_wdata     = ott_pkg::MODE_DEAD;
    cnt_we         = 1'b0;
    cnt_wdata      = '0;
    own_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          delay_nxt   = in_delay;
          unit_nxt    = in_unit_mode;
          owner_nxt   = in_owner_tag;
          ownv_nxt    = in_owner_valid;
          now_nxt     = in_now_seconds;
          id_bad_nxt  = (in_slot_id >= ott_pkg::IdW'(NUM_SLOTS));
          exp_cnt_nxt = '0;
          idx_nxt     = '0;
          unique case (in_func)
            ott_pkg::FUNC_CREATE: begin
              idx_nxt   = in_slot_id[IW-1:0];
              state_nxt = S_CRE;
            end
            ott_pkg::FUNC_DESTROY: begin
              idx_nxt   = in_slot_id[IW-1:0];
              state_nxt = S_DES;
            end
            ott_pkg::FUNC_FIND: state_nxt = S_FND;
            default:            state_nxt = S_TRD;
          endcase
        end
      end

      S_CRE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = ott_pkg::KIND_REPLY;
          out_status_nxt = cre_status;
          out_found_nxt  = '0;
          out_owner_nxt  = '0;
          out_last_nxt   = 1'b1;
          if (cre_status == ott_pkg::STAT_OK) begin
            mode_we    = 1'b1;
            mode_wdata = ott_pkg::mode_t'(unit_r);
            cnt_we     = 1'b1;
            cnt_wdata  = (unit_r == ott_pkg::MODE_TICKS) ? delay_r : dl_sat;
            own_we     = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      S_DES: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = ott_pkg::KIND_REPLY;
          out_status_nxt = id_bad_r ? ott_pkg::STAT_BAD_ID : ott_pkg::STAT_OK;
          out_found_nxt  = '0;
          out_owner_nxt  = '0;
          out_last_nxt   = 1'b1;
          mode_we        = !id_bad_r;
          mode_wdata     = ott_pkg::MODE_DEAD;
          state_nxt      = S_IDLE;
        end
      end

      S_FND: begin
        if (cur_mode == ott_pkg::MODE_DEAD || idx_r == LastIdx) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = ott_pkg::KIND_REPLY;
            out_owner_nxt = '0;
            out_last_nxt  = 1'b1;
            if (cur_mode == ott_pkg::MODE_DEAD) begin
              out_status_nxt = ott_pkg::STAT_OK;
              out_found_nxt  = ott_pkg::FoundW'(idx_r);
            end else begin
              out_status_nxt = ott_pkg::STAT_BAD_ID;
              out_found_nxt  = '0;
            end
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      S_TRD: state_nxt = S_TEV;

      S_TEV: begin
        // hold while an expiry cannot be handed to the output register
        if (!fire || out_free) begin
          if (cur_mode == ott_pkg::MODE_TICKS) begin
            cnt_we    = 1'b1;
            cnt_wdata = fire ? '0 : (cnt_rd_r - ott_pkg::DataW'(1));
          end
          if (fire) begin
            mode_we        = 1'b1;
            mode_wdata     = ott_pkg::MODE_DEAD;
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = ott_pkg::KIND_EXPIRY;
            out_status_nxt = ott_pkg::STAT_OK;
            out_found_nxt  = ott_pkg::FoundW'(idx_r);
            out_owner_nxt  = own_rd_r;
            out_last_nxt   = 1'b0;
            exp_cnt_nxt    = exp_cnt_r + ott_pkg::ExpCntW'(1);
          end
          if (idx_r == LastIdx ||
              (fire && exp_cnt_r == ott_pkg::ExpCntW'(ott_pkg::MaxExpiry - 1))) begin
            state_nxt = S_TEND;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_TRD;
          end
        end
      end

      S_TEND: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = ott_pkg::KIND_END;
          out_status_nxt = ott_pkg::STAT_OK;
          out_found_nxt  = '0;
          out_owner_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer state, request registers, slot modes and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      exp_cnt_r   <= '0;
      idx_r       <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        mode_r[i] <= ott_pkg::MODE_DEAD;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      idx_r       <= idx_nxt;
      if (mode_we) begin
        mode_r[idx_r] <= mode_wdata;
      end
    end
    id_bad_r     <= id_bad_nxt;
    delay_r      <= delay_nxt;
    unit_r       <= unit_nxt;
    owner_r      <= owner_nxt;
    ownv_r       <= ownv_nxt;
    now_r        <= now_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_owner_r  <= out_owner_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Count and owner memories: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[idx_r] <= cnt_wdata;
    end
    if (own_we) begin
      own_mem[idx_r] <= owner_r;
    end
    if (state_r == S_TRD) begin
      cnt_rd_r <= cnt_mem[idx_r];
      own_rd_r <= own_mem[idx_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_status        = out_status_r;
  assign out_found_id      = out_found_r;
  assign out_expired_owner = out_owner_r;
  assign out_last          = out_last_r;

  // An accepted request keeps the input closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not stalled after accepted request");

  // Expiries never close a request; replies and end-of-tick always do.
  a_last_by_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_kind_r != ott_pkg::KIND_EXPIRY)))
    else $error("last flag does not match result kind");

  // Expiry count stays within the per-tick cap.
  a_exp_cap: assert property (@(posedge clk) disable iff (!rst_n)
    exp_cnt_r <= ott_pkg::ExpCntW'(ott_pkg::MaxExpiry))
    else $error("expiry count above cap");

  // A reported expiry kills its slot.
  a_fire_kills: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEV && fire && out_free) |=>
      (mode_r[$past(idx_r)] == ott_pkg::MODE_DEAD))
    else $error("expired slot still armed");

  // An evaluate cycle is always preceded by a memory read cycle.
  a_read_before_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEV && $past(state_r) != S_TEV) |-> ($past(state_r) == S_TRD))
    else $error("slot evaluated without memory read");

endmodule
